// ===== sv/ckse_pkg.sv =====
`default_nettype none

package ckse_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    localparam int PIX_W     = 32;
    localparam int PAL_IDX_W = 8;
    localparam int KEY_W     = 24;
    localparam int DIM_W     = 13;
    localparam int COL_W     = 13;
    localparam int ROW_W     = 12;
    localparam int LEFT_W    = 12;
    localparam int NUM_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);
    localparam logic [NUM_W-1:0] NUM_MAX      = '1;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        FMT_PAL8   = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_RGB32  = 2'd3
    } pix_fmt_t;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_KEY_COLOR    = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_idx_t;

    // Zero acts as one; anything above the limit acts as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ckse_ram.sv =====
`default_nettype none

module ckse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/color_key_span_extractor_top.sv =====
// Color key span extractor.
// Requests enter on the s_ side: s_tuser = 0 carries a pixel, s_tuser = 1
// writes one palette entry. Pixels come in raster order, top row first.
// Every horizontal run of pixels that differ from the key color is sent on
// the m_ side as one span: left column, exclusive right column, row and a
// saturating span count. A run closes at a key pixel or at the end of a row.
// The block takes one request per clock while s_tready is high. The pixel
// that closes a span passes the input register and the palette read, then
// the run update writes the span into the output register behind m_tvalid.
// The pipeline keeps moving while m_tready is low until the output register
// and both internal stages are full; s_tready then drops.
// Configuration writes on cfg_wr_en also apply to pixels already accepted and
// do not disturb the position or an open run; write them only while idle.
// Reset clears the position, the open run and the span count, and sets the
// registers to 24-bit pixels, key color zero and a 640 by 480 image. The
// palette is not cleared: every entry that a pixel reads must be written first.
`default_nettype none

module color_key_span_extractor_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pixel_value[31:0], palette_index[39:32], palette_entry[71:40]
    input  wire logic [ckse_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // span_left[11:0], span_right[24:12], span_row[36:25], span_number[60:37],
    // zero[63:61]
    output logic      [ckse_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_addr,
    input  wire logic [ckse_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import ckse_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    pix_fmt_t          pixel_format_reg;
    logic [KEY_W-1:0]  key_color_reg;
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;

    logic                 s1_valid_reg;
    logic                 s1_type_reg;
    logic [PIX_W-1:0]     s1_pixel_reg;
    logic [PAL_IDX_W-1:0] s1_pindex_reg;
    logic [PIX_W-1:0]     s1_pentry_reg;

    logic             s2_valid_reg;
    logic [PIX_W-1:0] s2_pixel_reg;
    logic [PIX_W-1:0] pal_rdata;

    logic              run_open_reg,  run_open_next;
    logic [LEFT_W-1:0] run_start_reg, run_start_next;
    logic [COL_W-1:0]  column_reg,    column_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [NUM_W-1:0]  spans_reg,     spans_next;

    logic              out_valid_reg;
    logic [LEFT_W-1:0] out_left_reg;
    logic [COL_W-1:0]  out_right_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [NUM_W-1:0]  out_num_reg;

    logic s2_adv;
    logic s2_fire;
    logic s1_adv;
    logic in_fire;

    logic [7:0]       key_r, key_g, key_b;
    logic [KEY_W-1:0] key24;
    logic [15:0]      key16;
    logic             opaque;

    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             emit;
    logic [COL_W-1:0] span_right;

    // Handshake and stage movement.
    assign s2_adv   = !out_valid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && s2_adv;
    assign s1_adv   = !s2_valid_reg || s2_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_RGB24;
            key_color_reg    <= '0;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PIXEL_FORMAT: pixel_format_reg <= pix_fmt_t'(cfg_wdata[1:0]);
                CFG_KEY_COLOR:    key_color_reg    <= cfg_wdata[KEY_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_type_reg   <= s_tuser;
            s1_pixel_reg  <= s_tdata[31:0];
            s1_pindex_reg <= s_tdata[39:32];
            s1_pentry_reg <= s_tdata[71:40];
        end
    end

    ckse_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (s1_valid_reg && s1_adv && (s1_type_reg == REQ_PALETTE)),
        .wr_addr (s1_pindex_reg[PAL_AW-1:0]),
        .wr_data (s1_pentry_reg),
        .rd_en   (s1_valid_reg && s1_adv && (s1_type_reg == REQ_PIXEL)),
        .rd_addr (s1_pixel_reg[PAL_AW-1:0]),
        .rd_data (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_type_reg == REQ_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_pixel_reg <= s1_pixel_reg;
        end
    end

    // The key arrives as RGB with red low and is compared as BGR.
    assign key_r = key_color_reg[7:0];
    assign key_g = key_color_reg[15:8];
    assign key_b = key_color_reg[23:16];
    assign key24 = {key_r, key_g, key_b};
    assign key16 = {key_r[7:3], key_g[7:2], key_b[7:3]};

    always_comb
    begin
        case (pixel_format_reg)
            FMT_PAL8:   opaque = pal_rdata != {8'h00, key24};
            FMT_RGB565: opaque = s2_pixel_reg[15:0] != key16;
            FMT_RGB24:  opaque = s2_pixel_reg[23:0] != key24;
            FMT_RGB32:  opaque = s2_pixel_reg != {8'h00, key24};
            default:    opaque = 1'b1;
        endcase
    end

    assign width_eff  = clamp_dim(image_width_reg, WIDTH_LIMIT);
    assign height_eff = clamp_dim(image_height_reg, HEIGHT_LIMIT);
    assign col_inc    = column_reg + COL_W'(1);
    assign row_inc    = row_reg + ROW_W'(1);

    always_comb
    begin
        emit           = 1'b0;
        span_right     = column_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        column_next    = col_inc;
        row_next       = row_reg;

        if (run_open_reg && !opaque)
        begin
            emit          = 1'b1;
            run_open_next = 1'b0;
        end
        else if (!run_open_reg && opaque)
        begin
            run_start_next = column_reg[LEFT_W-1:0];
            run_open_next  = 1'b1;
        end

        if (col_inc >= width_eff)
        begin
            if (run_open_next)
            begin
                emit          = 1'b1;
                span_right    = col_inc;
                run_open_next = 1'b0;
            end
            column_next = '0;
            if (({1'b0, row_inc} >= height_eff) || (row_inc == '0))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_inc;
            end
        end

        if (emit && (spans_reg != NUM_MAX))
        begin
            spans_next = spans_reg + NUM_W'(1);
        end
        else
        begin
            spans_next = spans_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            spans_reg     <= '0;
        end
        else if (s2_fire)
        begin
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            spans_reg     <= spans_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= s2_fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && emit)
        begin
            out_left_reg  <= run_start_next;
            out_right_reg <= span_right;
            out_row_reg   <= row_reg;
            out_num_reg   <= spans_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_num_reg, out_row_reg, out_right_reg, out_left_reg};

`ifndef SYNTHESIS
    a_span_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_left_reg} < out_right_reg))
        else $error("span right edge not past its left edge");

    a_span_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_num_reg != '0))
        else $error("span sent with a zero span count");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg < WIDTH_LIMIT)
        else $error("column position past the widest row");

    a_open_run_behind: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> ({1'b0, run_start_reg} < column_reg))
        else $error("open run starts at or past the current column");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_fire |=> ($stable(column_reg) && $stable(row_reg) && $stable(spans_reg)))
        else $error("position moved without a pixel being processed");
`endif

endmodule

`default_nettype wire
